// ----- hw/rtl/short_name_formatter_assert.svh -----
// Assertion macros for the short name formatter.
`ifndef SHORT_NAME_FORMATTER_ASSERT_SVH
`define SHORT_NAME_FORMATTER_ASSERT_SVH

`ifndef SYNTH

`define SNF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

`define SNF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define SNF_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define SNF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/snf_pkg.sv -----
// Types, constants and helpers shared by the short name formatter modules.
package snf_pkg;

   localparam int STORE_DEPTH = 12;
   localparam int NAME_BYTES  = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_BYTE = 8'h20;
   localparam logic [7:0] DOT_BYTE = 8'h2E;
   localparam logic [7:0] UPPER_A  = 8'h41;
   localparam logic [7:0] UPPER_Z  = 8'h5A;
   localparam logic [7:0] LOWER_A  = 8'h61;
   localparam logic [7:0] LOWER_Z  = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;
   localparam logic [7:0] NUL_BYTE = 8'h00;

   localparam logic [3:0] BASE_MAX    = 4'd8;
   localparam logic [4:0] EXT_MAX     = 5'd3;
   localparam logic [3:0] STORE_LIMIT = 4'd12;
   localparam logic [3:0] COUNT_MAX   = 4'd15;
   localparam logic [1:0] DOTS_MAX    = 2'd3;
   localparam logic [3:0] LAST_INDEX  = 4'd10;

   localparam logic [1:0] KIND_LONG   = 2'd0;
   localparam logic [1:0] KIND_SHORT  = 2'd1;
   localparam logic [1:0] KIND_PARENT = 2'd2;

   typedef struct packed {
      logic [STORE_DEPTH-1:0][7:0] chars;
      logic [1:0]                  kind;
      logic [3:0]                  base_len;
      logic [1:0]                  ext_len;
      logic [3:0]                  count;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= LOWER_A && c <= LOWER_Z) begin
         r = c - CASE_GAP;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/snf_front.sv -----
// Front end: takes name characters, keeps counters and classifies at the terminator.
module snf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] character
   input  snf_pkg::q_status_type q_status,
   output snf_pkg::push_type    push
);

   logic [snf_pkg::STORE_DEPTH-1:0][7:0] store_ff, store_in;
   logic [3:0] count_ff, count_in;
   logic [1:0] dots_ff, dots_in;
   logic [3:0] dot_pos_ff, dot_pos_in;
   logic       cap_ff, cap_in;

   logic       accept;
   logic       parent;
   logic [3:0] base_len;
   logic [4:0] ext_full;
   logic       compat;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   // terminator classification
   always_comb begin
      parent = (count_ff == 4'd2) && (store_ff[0] == snf_pkg::DOT_BYTE)
               && (store_ff[1] == snf_pkg::DOT_BYTE);
      if (dots_ff != 2'd0) begin
         base_len = dot_pos_ff;
         ext_full = {1'b0, count_ff} - {1'b0, dot_pos_ff} - 5'd1;
      end else begin
         base_len = count_ff;
         ext_full = 5'd0;
      end
      compat = !cap_ff && (dots_ff <= 2'd1) && (base_len <= snf_pkg::BASE_MAX)
               && (ext_full <= snf_pkg::EXT_MAX);
   end

   always_comb begin
      store_in   = store_ff;
      count_in   = count_ff;
      dots_in    = dots_ff;
      dot_pos_in = dot_pos_ff;
      cap_in     = cap_ff;
      push.valid = 1'b0;
      push.desc.chars    = store_ff;
      push.desc.base_len = base_len;
      push.desc.ext_len  = ext_full[1:0];
      push.desc.count    = count_ff;
      if (parent) begin
         push.desc.kind = snf_pkg::KIND_PARENT;
      end else if (compat) begin
         push.desc.kind = snf_pkg::KIND_SHORT;
      end else begin
         push.desc.kind = snf_pkg::KIND_LONG;
      end
      if (accept) begin
         if (req_tdata == snf_pkg::NUL_BYTE) begin
            push.valid = 1'b1;
            count_in   = 4'd0;
            dots_in    = 2'd0;
            dot_pos_in = 4'd0;
            cap_in     = 1'b0;
         end else begin
            if (count_ff < snf_pkg::STORE_LIMIT) begin
               store_in[count_ff] = req_tdata;
            end
            if (req_tdata == snf_pkg::DOT_BYTE) begin
               dot_pos_in = count_ff;
               if (dots_ff != snf_pkg::DOTS_MAX) begin
                  dots_in = dots_ff + 2'd1;
               end
            end else if (req_tdata >= snf_pkg::UPPER_A && req_tdata <= snf_pkg::UPPER_Z) begin
               cap_in = 1'b1;
            end
            if (count_ff != snf_pkg::COUNT_MAX) begin
               count_in = count_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      if (reset) begin
         count_ff   <= 4'd0;
         dots_ff    <= 2'd0;
         dot_pos_ff <= 4'd0;
         cap_ff     <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dots_ff    <= dots_in;
         dot_pos_ff <= dot_pos_in;
         cap_ff     <= cap_in;
      end
   end

endmodule

// ----- hw/rtl/snf_queue.sv -----
// Small descriptor queue between the front and the back end.
module snf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  snf_pkg::push_type     push,
   input  logic                  pop,
   output snf_pkg::desc_type     head,
   output snf_pkg::q_status_type status
);

   snf_pkg::desc_type entry_ff [snf_pkg::QUEUE_DEPTH];
   logic [snf_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [snf_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [snf_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign status.full  = (count_ff == snf_pkg::QCNT_W'(snf_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];
   assign do_push      = push.valid && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == snf_pkg::QPTR_W'(snf_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + snf_pkg::QPTR_W'(1);
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == snf_pkg::QPTR_W'(snf_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + snf_pkg::QPTR_W'(1);
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + snf_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - snf_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/snf_back.sv -----
// Back end: walks a descriptor and emits the 11 directory name bytes.
module snf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  snf_pkg::desc_type     head,
   input  snf_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] name_byte
   output logic [2:0]            rsp_tuser,   // [1:0] name_kind, [2] long_name_flag
   output logic                  rsp_tlast    // last_byte
);

   logic [3:0] index_ff, index_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] kind_ff;
   logic       last_ff;

   logic       load;
   logic [7:0] sel_byte;
   logic [1:0] ext_k;
   logic [3:0] ext_idx;

   assign load = !q_status.empty && (!valid_ff || rsp_tready);
   assign pop  = load && (index_ff == snf_pkg::LAST_INDEX);

   always_comb begin
      ext_k   = index_ff[1:0];
      ext_idx = head.base_len + 4'd1 + {2'b00, ext_k};
      sel_byte = snf_pkg::PAD_BYTE;
      if (head.kind == snf_pkg::KIND_SHORT) begin
         if (index_ff < snf_pkg::BASE_MAX) begin
            if (index_ff < head.base_len) begin
               sel_byte = snf_pkg::upcase(head.chars[index_ff]);
            end
         end else if (ext_k < head.ext_len) begin
            sel_byte = snf_pkg::upcase(head.chars[ext_idx]);
         end
      end else if (index_ff < head.count) begin
         sel_byte = head.chars[index_ff];
      end
   end

   always_comb begin
      index_in = index_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         if (index_ff == snf_pkg::LAST_INDEX) begin
            index_in = 4'd0;
         end else begin
            index_in = index_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (load) begin
         kind_ff <= head.kind;
         last_ff <= (index_ff == snf_pkg::LAST_INDEX);
      end
      if (reset) begin
         index_ff <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {(kind_ff == snf_pkg::KIND_LONG), kind_ff};
   assign rsp_tlast  = last_ff;

endmodule

// ----- hw/rtl/short_name_formatter.sv -----
// A terminator pushes a descriptor into the queue; the first name byte is then
// registered from the queue head. One character per cycle in while the queue
// has room; eleven name bytes out, one per cycle while rsp_tready is high.
// The two-entry descriptor queue lets the next name stream in during output.
// Reset clears counters, queue and output valid; the character store is not cleared.
`include "short_name_formatter_assert.svh"

module short_name_formatter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] character
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] name_byte
   output logic [2:0] rsp_tuser,   // [1:0] name_kind, [2] long_name_flag
   output logic       rsp_tlast    // last_byte
);

   snf_pkg::push_type     push;
   snf_pkg::q_status_type q_status;
   snf_pkg::desc_type     head;
   logic                  pop;

   snf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push)
   );

   snf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   snf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `SNF_ASSERT_IMPLY(a_push_not_full, clock, reset, push.valid, !q_status.full)
   `SNF_ASSERT_IMPLY(a_pop_not_empty, clock, reset, pop, !q_status.empty)
   `SNF_ASSERT_IMPLY(a_flag_matches_kind, clock, reset, rsp_tvalid, rsp_tuser[2] == (rsp_tuser[1:0] == snf_pkg::KIND_LONG))
   `SNF_ASSERT_NEXT(a_last_after_pop, clock, reset, pop, rsp_tvalid && rsp_tlast)

endmodule

// ----- sim/short_name_formatter_checker.sv -----
// Checker for the short name formatter: predicts the directory name bytes and compares them.
`timescale 1ns / 1ps

module short_name_formatter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int unsigned fail_count,
   output int unsigned pending
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] name_byte;
      logic [1:0] kind;
      logic       long_flag;
      logic       last;
   } dir_byte_type;

   logic [7:0]   name_store [snf_pkg::STORE_DEPTH];
   logic [3:0]   name_len;
   logic [1:0]   dot_total;
   logic [3:0]   last_dot;
   logic         has_capital;
   dir_byte_type dir_bytes [$];

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      if (c >= snf_pkg::LOWER_A && c <= snf_pkg::LOWER_Z) begin
         return c & 8'hDF;
      end
      return c;
   endfunction

   function automatic logic [7:0] held_char(input int idx);
      if (idx < snf_pkg::STORE_DEPTH && idx < int'(name_len)) begin
         return name_store[idx];
      end
      return snf_pkg::PAD_BYTE;
   endfunction

   task automatic close_name();
      logic [7:0]   bytes [snf_pkg::NAME_BYTES];
      logic [1:0]   kind;
      int           base_len;
      int           ext_len;
      dir_byte_type entry;
      base_len = 0;
      ext_len  = 0;
      if (name_len == 4'd2 && name_store[0] == snf_pkg::DOT_BYTE
          && name_store[1] == snf_pkg::DOT_BYTE) begin
         kind = snf_pkg::KIND_PARENT;
      end else begin
         kind = has_capital ? snf_pkg::KIND_LONG : snf_pkg::KIND_SHORT;
         if (dot_total != 2'd0) begin
            base_len = int'(last_dot);
            ext_len  = int'(name_len) - base_len - 1;
         end else begin
            base_len = int'(name_len);
         end
         if (dot_total > 2'd1 || base_len > int'(snf_pkg::BASE_MAX)
             || ext_len > int'(snf_pkg::EXT_MAX) || ext_len < 0) begin
            kind = snf_pkg::KIND_LONG;
         end
      end
      for (int i = 0; i < snf_pkg::NAME_BYTES; i++) begin
         bytes[i] = snf_pkg::PAD_BYTE;
      end
      if (kind == snf_pkg::KIND_SHORT) begin
         for (int i = 0; i < base_len; i++) begin
            bytes[i] = to_upper(held_char(i));
         end
         for (int i = 0; i < ext_len; i++) begin
            bytes[int'(snf_pkg::BASE_MAX) + i] = to_upper(held_char(base_len + 1 + i));
         end
      end else begin
         for (int i = 0; i < snf_pkg::NAME_BYTES; i++) begin
            bytes[i] = held_char(i);
         end
      end
      for (int i = 0; i < snf_pkg::NAME_BYTES; i++) begin
         entry.name_byte = bytes[i];
         entry.kind      = kind;
         entry.long_flag = (kind == snf_pkg::KIND_LONG);
         entry.last      = (i == snf_pkg::NAME_BYTES - 1);
         dir_bytes.push_back(entry);
      end
      name_len    = 4'd0;
      dot_total   = 2'd0;
      last_dot    = 4'd0;
      has_capital = 1'b0;
   endtask

   task automatic take_char(input logic [7:0] c);
      if (c == snf_pkg::NUL_BYTE) begin
         close_name();
      end else begin
         if (name_len < snf_pkg::STORE_LIMIT) begin
            name_store[name_len] = c;
         end
         if (c == snf_pkg::DOT_BYTE) begin
            last_dot = name_len;
            if (dot_total < snf_pkg::DOTS_MAX) begin
               dot_total++;
            end
         end else if (c >= snf_pkg::UPPER_A && c <= snf_pkg::UPPER_Z) begin
            has_capital = 1'b1;
         end
         if (name_len < snf_pkg::COUNT_MAX) begin
            name_len++;
         end
      end
   endtask

   task automatic check_byte();
      dir_byte_type got;
      dir_byte_type want;
      got = {rsp_tdata, rsp_tuser[1:0], rsp_tuser[2], rsp_tlast};
      if (dir_bytes.size() == 0) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS) begin
            $display("unexpected name byte: byte %h kind %0d long %0b last %0b",
                     got.name_byte, got.kind, got.long_flag, got.last);
         end
      end else begin
         want = dir_bytes.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display({"name byte mismatch: expected byte %h kind %0d long %0b last %0b,",
                         " got byte %h kind %0d long %0b last %0b"},
                        want.name_byte, want.kind, want.long_flag, want.last,
                        got.name_byte, got.kind, got.long_flag, got.last);
            end
         end
      end
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         name_len    = 4'd0;
         dot_total   = 2'd0;
         last_dot    = 4'd0;
         has_capital = 1'b0;
         dir_bytes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_byte();
         end
         if (req_tvalid && req_tready) begin
            take_char(req_tdata);
         end
      end
      pending = dir_bytes.size();
   end

endmodule

// ----- sim/tb_top.sv -----
// Top of the short name formatter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int ITEM_TARGET  = 180;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] character
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] name_byte
   logic [2:0]  rsp_tuser;   // [1:0] name_kind, [2] long_name_flag
   logic        rsp_tlast;
   int unsigned fail_count;
   int unsigned pending;
   int unsigned cycle_count   = 0;
   int unsigned chars_sent    = 0;
   bit          calm_source   = 1'b0;
   bit          directed_done = 1'b0;
   bit          hold_done     = 1'b0;
   logic [7:0]  name_chars [$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   short_name_formatter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   short_name_formatter_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // never a capital or a dot
   function automatic logic [7:0] plain_char();
      case ($urandom_range(0, 6))
         0, 1, 2: begin
            return 8'($urandom_range(snf_pkg::LOWER_A, snf_pkg::LOWER_Z));
         end
         3: begin
            return 8'($urandom_range(8'h2F, 8'h40));
         end
         4: begin
            return 8'($urandom_range(8'h5B, 8'h60));
         end
         5: begin
            return 8'($urandom_range(8'h7B, 8'hFF));
         end
         default: begin
            return 8'($urandom_range(8'h01, 8'h2D));
         end
      endcase
   endfunction

   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = calm_source ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_name();
      foreach (name_chars[i]) begin
         send_char(name_chars[i]);
      end
      send_char(snf_pkg::NUL_BYTE);
   endtask

   task automatic send_text(input string s);
      name_chars.delete();
      for (int i = 0; i < s.len(); i++) begin
         name_chars.push_back(s[i]);
      end
      send_name();
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("short_name_formatter regression: fail");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold while names keep coming
   initial begin
      rsp_tready <= 1'b0;
      @(negedge clock);
      forever begin
         if (directed_done && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 25)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (idle_len() + 1) @(negedge clock);
         end
      end
   end

   initial begin
      int pos;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= snf_pkg::NUL_BYTE;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_text("");
      send_text("..");
      send_text("Za.b");
      name_chars = {8'h01, 8'hFF, snf_pkg::DOT_BYTE};
      send_name();
      send_text("abcdefghi");
      directed_done = 1'b1;

      while (chars_sent < ITEM_TARGET) begin
         calm_source = ($urandom_range(0, 4) == 0);
         name_chars.delete();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               repeat ($urandom_range(0, 8)) name_chars.push_back(plain_char());
               if ($urandom_range(0, 3) != 0) begin
                  name_chars.push_back(snf_pkg::DOT_BYTE);
                  repeat ($urandom_range(0, 3)) name_chars.push_back(plain_char());
               end
               if ($urandom_range(0, 4) == 0 && name_chars.size() > 0) begin
                  pos = $urandom_range(0, name_chars.size() - 1);
                  name_chars[pos] = 8'($urandom_range(snf_pkg::UPPER_A, snf_pkg::UPPER_Z));
               end
            end
            5: begin
               repeat ($urandom_range(1, 3)) name_chars.push_back(snf_pkg::DOT_BYTE);
               if ($urandom_range(0, 2) == 0) begin
                  name_chars.push_back(plain_char());
               end
            end
            6: begin
               repeat ($urandom_range(9, 18)) begin
                  name_chars.push_back(($urandom_range(0, 5) == 0) ?
                                       snf_pkg::DOT_BYTE : plain_char());
               end
            end
            7: begin
               repeat ($urandom_range(7, 9)) name_chars.push_back(plain_char());
               name_chars.push_back(snf_pkg::DOT_BYTE);
               repeat ($urandom_range(2, 4)) name_chars.push_back(plain_char());
            end
            default: begin
               repeat ($urandom_range(0, 15)) name_chars.push_back(8'($urandom_range(1, 255)));
            end
         endcase
         send_name();
      end
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("short_name_formatter regression: pass");
      end else begin
         $display("short_name_formatter regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/snf_pkg.sv
hw/rtl/snf_front.sv
hw/rtl/snf_queue.sv
hw/rtl/snf_back.sv
hw/rtl/short_name_formatter.sv
sim/short_name_formatter_checker.sv
sim/tb_top.sv
